// File: hdl/lbc_pkg.sv
// ============================================================================
// lbc_pkg: shared types and constants of the LRU block cache.
// Holds geometry, status codes, opcodes and register indexes.
// ============================================================================
`default_nettype none

package lbc_pkg;

  localparam int Entries       = 64;
  localparam int BlockWords    = 32;
  localparam int NumDisks      = 16;
  localparam int BlocksPerDisk = 256;

  localparam int EntW  = $clog2(Entries);
  localparam int BeatW = (BlockWords > 1) ? $clog2(BlockWords) : 1;
  localparam int AddrW = EntW + BeatW;
  localparam int CntW  = $clog2(Entries + 1);
  localparam int DiskW = 8;
  localparam int BlkW  = 10;

  localparam logic [1:0] OP_LOOKUP  = 2'd0;
  localparam logic [1:0] OP_UPDATE  = 2'd1;
  localparam logic [1:0] OP_INSERT  = 2'd2;
  localparam logic [1:0] OP_INVALID = 2'd3;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_MISS     = 2'd1;
  localparam logic [1:0] ST_REJECT   = 2'd2;
  localparam logic [1:0] ST_DISABLED = 2'd3;

  localparam logic REG_ENABLE  = 1'b0;
  localparam logic REG_ENTRIES = 1'b1;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [7:0]  disk_number;
    logic [9:0]  block_number;
    logic [63:0] data_word;
  } req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [63:0] read_word;
    logic        last_of_run;
    logic [31:0] queries_seen;
    logic [31:0] hits_seen;
  } rsp_t;

  typedef struct packed {
    logic        wr_en;
    logic [63:0] wr_data;
    logic        rd_en;
    logic [AddrW-1:0] addr;
  } mem_ctl_t;

  // Saturating 32-bit increment.
  function automatic logic [31:0] sat_inc(input logic [31:0] v);
    logic [31:0] r;
    r = (v == '1) ? v : v + 32'd1;
    return r;
  endfunction

endpackage

`default_nettype wire

// File: hdl/lbc_if.sv
// ============================================================================
// lbc_if: valid/ready channel interfaces of the LRU block cache.
// A word moves when valid and ready are both high at a rising clock edge.
// ============================================================================
`default_nettype none

interface lbc_req_if;
  logic          valid;
  logic          ready;
  lbc_pkg::req_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface lbc_rsp_if;
  logic          valid;
  logic          ready;
  lbc_pkg::rsp_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface lbc_cfg_if;
  logic        valid;
  logic        ready;
  logic        index;
  logic [31:0] wdata;
  modport source (output valid, output index, output wdata, input ready);
  modport sink   (input valid, input index, input wdata, output ready);
endinterface

`default_nettype wire

// File: hdl/lbc_data_ram.sv
// ============================================================================
// lbc_data_ram: block data store.
// Single port synchronous RAM with a registered read, one access per cycle.
// ============================================================================
`default_nettype none

module lbc_data_ram (
  input  wire logic              clk_i,
  input  wire lbc_pkg::mem_ctl_t ctl_i,
  output logic [63:0]            rd_data_o
);
  import lbc_pkg::*;

  logic [63:0] mem [2**AddrW];

  // Write or read one word each cycle.
  always_ff @(posedge clk_i) begin
    if (ctl_i.wr_en) begin
      mem[ctl_i.addr] <= ctl_i.wr_data;
    end
    if (ctl_i.rd_en) begin
      rd_data_o <= mem[ctl_i.addr];
    end
  end

endmodule

`default_nettype wire

// File: hdl/lbc_tag_array.sv
// ============================================================================
// lbc_tag_array: entry tags, stamps and valid marks.
// Compares every entry in the active range against a key and picks the LRU victim, registered.
// ============================================================================
`default_nettype none

module lbc_tag_array (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    clear_i,
  input  wire logic [lbc_pkg::CntW-1:0] active_i,
  input  wire logic [7:0]              disk_i,
  input  wire logic [9:0]              block_i,
  input  wire logic                    search_i,
  output logic                         hit_o,
  output logic [lbc_pkg::EntW-1:0]     hit_idx_o,
  output logic [lbc_pkg::EntW-1:0]     victim_o,
  input  wire logic                    wr_i,
  input  wire logic                    wr_tag_i,
  input  wire logic [lbc_pkg::EntW-1:0] wr_idx_i,
  input  wire logic [31:0]             wr_stamp_i
);
  import lbc_pkg::*;

  logic [Entries-1:0] valid_q;
  logic [3:0]  disk_q  [Entries];
  logic [7:0]  block_q [Entries];
  logic [31:0] stamp_q [Entries];

  logic [Entries-1:0] match;
  logic [Entries-1:0] in_use;

  // Per-entry compare over the active range.
  always_comb begin
    for (int i = 0; i < Entries; i++) begin
      in_use[i] = (CntW'(i) < active_i);
      match[i]  = in_use[i] && valid_q[i] &&
                  ({4'd0, disk_q[i]} == disk_i) && ({2'd0, block_q[i]} == block_i);
    end
  end

  // Priority pick of the lowest matching entry.
  logic            any_hit;
  logic [EntW-1:0] hit_idx;
  always_comb begin
    any_hit = 1'b0;
    hit_idx = '0;
    for (int i = Entries - 1; i >= 0; i--) begin
      if (match[i]) begin
        any_hit = 1'b1;
        hit_idx = EntW'(i);
      end
    end
  end

  // Victim: first invalid entry, else lowest stamp with lowest index on ties.
  // The stamp minimum is a balanced tree whose left branch wins ties.
  logic            any_free;
  logic [EntW-1:0] free_idx;
  logic [EntW-1:0] best;
  logic [31:0]     node_stamp [2*Entries];
  logic [EntW-1:0] node_idx   [2*Entries];
  logic            node_use   [2*Entries];
  always_comb begin
    any_free = 1'b0;
    free_idx = '0;
    for (int i = Entries - 1; i >= 0; i--) begin
      if (in_use[i] && !valid_q[i]) begin
        any_free = 1'b1;
        free_idx = EntW'(i);
      end
    end
    node_stamp[0] = '0;
    node_idx[0]   = '0;
    node_use[0]   = 1'b0;
    for (int i = 0; i < Entries; i++) begin
      node_stamp[Entries + i] = stamp_q[i];
      node_idx[Entries + i]   = EntW'(i);
      node_use[Entries + i]   = in_use[i];
    end
    for (int n = Entries - 1; n >= 1; n--) begin
      if (node_use[2*n] &&
          (!node_use[2*n+1] || node_stamp[2*n] <= node_stamp[2*n+1])) begin
        node_stamp[n] = node_stamp[2*n];
        node_idx[n]   = node_idx[2*n];
      end else begin
        node_stamp[n] = node_stamp[2*n+1];
        node_idx[n]   = node_idx[2*n+1];
      end
      node_use[n] = node_use[2*n] || node_use[2*n+1];
    end
    best = node_idx[1];
  end

  // Search results register.
  always_ff @(posedge clk_i) begin
    if (search_i) begin
      hit_o     <= any_hit;
      hit_idx_o <= hit_idx;
      victim_o  <= any_free ? free_idx : best;
    end
  end

  // Valid marks.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (clear_i) begin
      valid_q <= '0;
    end else if (wr_i && wr_tag_i) begin
      valid_q[wr_idx_i] <= 1'b1;
    end
  end

  // Tag and stamp write.
  always_ff @(posedge clk_i) begin
    if (wr_i) begin
      stamp_q[wr_idx_i] <= wr_stamp_i;
      if (wr_tag_i) begin
        disk_q[wr_idx_i]  <= disk_i[3:0];
        block_q[wr_idx_i] <= block_i[7:0];
      end
    end
  end

endmodule

`default_nettype wire

// File: hdl/lru_block_cache_unit.sv
// ============================================================================
// lru_block_cache_unit: fully associative LRU block cache.
// Sequencer around the tag array and the block data RAM.
// ============================================================================
// Usage: words enter on req (opcode, key, data). A lookup takes one word;
// it answers with a miss or disabled status, or on a hit streams
// BlockWords words with last_of_run on the final one. Update and insert take
// BlockWords words and answer once, on the last one. Configuration writes
// go on cfg: index 0 sets enable from wdata[0] and clears all valid marks,
// index 1 sets the number of entries in use.
// The first word of any operation passes the tag search state and then the
// act state; the status is registered in the act state, and the next first
// word is taken back in the idle state once the output register is free.
// Later data words of an update or insert are taken one per cycle, each
// written straight into the data RAM if the status is OK. A lookup hit reads
// one word per cycle from the single RAM port unless the receiver stalls,
// via the RAM output register. One operation is in flight at a time.
// Reset clears all valid marks, counters and the sequencer; the cache comes
// up disabled with all 64 entries in use. When the receiver stalls, the
// output register holds, a word already read waits at the RAM output and
// the read stream pauses with it.
// ============================================================================
`default_nettype none

module lru_block_cache_unit (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  lbc_req_if.sink   req,
  lbc_rsp_if.source rsp,
  lbc_cfg_if.sink   cfg
);
  import lbc_pkg::*;

  localparam logic [2:0] S_FIRST  = 3'd0;
  localparam logic [2:0] S_SEARCH = 3'd1;
  localparam logic [2:0] S_BEATS  = 3'd2;
  localparam logic [2:0] S_STREAM = 3'd3;
  localparam logic [2:0] S_WAIT   = 3'd4;

  logic [2:0]      state_q, state_d;
  logic            enable_q;
  logic [CntW-1:0] active_q;
  logic [31:0]     stamp_q, queries_q, hits_q;
  logic [BeatW-1:0] beat_q;
  logic [EntW-1:0] pend_q;
  logic [1:0]      pend_st_q;
  req_t            first_q;
  logic [BeatW:0]  rd_cnt_q;
  logic            rd_pend_q;

  // Output register.
  logic out_v_q;
  rsp_t out_q;
  assign rsp.valid = out_v_q;
  assign rsp.data  = out_q;
  wire out_free = !out_v_q || rsp.ready;

  // Config port.
  assign cfg.ready = 1'b1;
  wire cfg_en_wr = cfg.valid && cfg.index == REG_ENABLE;

  wire acc = req.valid && req.ready;
  assign req.ready = (state_q == S_FIRST && out_free) || state_q == S_BEATS;

  // Tag array.
  logic            hit;
  logic [EntW-1:0] hit_idx, victim;
  logic            t_wr, t_wr_tag;
  logic [EntW-1:0] t_idx;

  lbc_tag_array u_tags (
    .clk_i, .rst_ni,
    .clear_i   (cfg_en_wr),
    .active_i  (active_q),
    .disk_i    (first_q.disk_number),
    .block_i   (first_q.block_number),
    .search_i  (state_q == S_SEARCH),
    .hit_o     (hit),
    .hit_idx_o (hit_idx),
    .victim_o  (victim),
    .wr_i      (t_wr),
    .wr_tag_i  (t_wr_tag),
    .wr_idx_i  (t_idx),
    .wr_stamp_i(sat_inc(stamp_q))
  );

  // Data RAM.
  mem_ctl_t    mctl;
  logic [63:0] rd_data;
  lbc_data_ram u_ram (.clk_i, .ctl_i(mctl), .rd_data_o(rd_data));

  // Decide outcome of the first word after the search cycle.
  logic       in_range;
  logic [1:0] dec_st;
  logic       wait_q;
  assign in_range = ({1'b0, first_q.disk_number} < 9'(NumDisks)) &&
                    ({1'b0, first_q.block_number} < 11'(BlocksPerDisk));
  always_comb begin
    dec_st   = ST_OK;
    t_wr     = 1'b0;
    t_wr_tag = 1'b0;
    t_idx    = hit_idx;
    if (!enable_q) begin
      dec_st = ST_DISABLED;
    end else begin
      case (first_q.opcode)
        OP_LOOKUP, OP_UPDATE: begin
          if (hit && in_range) t_wr = wait_q;
          else dec_st = ST_MISS;
        end
        OP_INSERT: begin
          if (!in_range || hit) dec_st = ST_REJECT;
          else begin
            t_wr = wait_q; t_wr_tag = 1'b1; t_idx = victim;
          end
        end
        default: dec_st = ST_REJECT;
      endcase
    end
  end

  wire last_beat = (beat_q == BeatW'(BlockWords - 1));
  wire stream_go = state_q == S_STREAM && rd_cnt_q != (BeatW+1)'(BlockWords) &&
                   (!rd_pend_q || out_free) && (!out_v_q || rsp.ready || !rd_pend_q);
  // The word waiting at the RAM output moves into the output register.
  wire stream_load = state_q == S_STREAM && rd_pend_q && out_free;

  // RAM control: first-word and beat writes, or stream reads.
  always_comb begin
    mctl.wr_en   = 1'b0;
    mctl.wr_data = req.data.data_word;
    mctl.rd_en   = 1'b0;
    mctl.addr    = {pend_q, beat_q};
    if (state_q == S_BEATS && acc) begin
      mctl.wr_en = (pend_st_q == ST_OK);
    end else if (wait_q && state_q == S_WAIT && first_q.opcode != OP_LOOKUP) begin
      mctl.wr_data = first_q.data_word;
      mctl.wr_en   = (dec_st == ST_OK);
      mctl.addr    = {t_idx, BeatW'(0)};
    end else if (stream_go) begin
      mctl.rd_en = 1'b1;
      mctl.addr  = {pend_q, rd_cnt_q[BeatW-1:0]};
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_FIRST:  if (acc) state_d = S_SEARCH;
      S_SEARCH: state_d = S_WAIT;
      S_WAIT:   state_d = S_FIRST;
      S_BEATS:  if (acc && last_beat) state_d = S_FIRST;
      S_STREAM: state_d = S_STREAM;
      default:  state_d = S_FIRST;
    endcase
  end

  assign wait_q = (state_q == S_WAIT);

  // Sequencer and counters.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_FIRST;
      enable_q  <= 1'b0;
      active_q  <= CntW'(Entries);
      stamp_q   <= '0;
      queries_q <= '0;
      hits_q    <= '0;
      beat_q    <= '0;
      pend_q    <= '0;
      pend_st_q <= ST_OK;
      out_v_q   <= 1'b0;
      rd_cnt_q  <= '0;
      rd_pend_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (out_v_q && rsp.ready) out_v_q <= 1'b0;
      if (cfg.valid) begin
        if (cfg.index == REG_ENABLE) begin
          enable_q <= cfg.wdata[0];
          state_q  <= S_FIRST;
          beat_q   <= '0;
        end else if (cfg.wdata[6:0] < 7'd2) begin
          active_q <= CntW'(2);
        end else if (cfg.wdata[6:0] > 7'(Entries)) begin
          active_q <= CntW'(Entries);
        end else begin
          active_q <= CntW'(cfg.wdata[6:0]);
        end
      end
      if (state_q == S_WAIT) begin
        pend_q    <= t_idx;
        pend_st_q <= dec_st;
        if (t_wr) stamp_q <= sat_inc(stamp_q);
        if (first_q.opcode == OP_LOOKUP && enable_q) begin
          queries_q <= sat_inc(queries_q);
          if (dec_st == ST_OK) hits_q <= sat_inc(hits_q);
        end
        if (first_q.opcode == OP_LOOKUP || first_q.opcode == OP_INVALID) begin
          if (first_q.opcode == OP_LOOKUP && dec_st == ST_OK) begin
            state_q  <= S_STREAM;
            rd_cnt_q <= '0;
          end else begin
            out_v_q <= 1'b1;
          end
        end else if (BlockWords == 1) begin
          out_v_q <= 1'b1;
        end else begin
          state_q <= S_BEATS;
          beat_q  <= BeatW'(1);
        end
      end
      if (state_q == S_BEATS && acc) begin
        beat_q <= beat_q + BeatW'(1);
        if (last_beat) begin
          beat_q  <= '0;
          out_v_q <= 1'b1;
        end
      end
      // A read word stays pending until the output register can take it.
      if (state_q == S_STREAM) begin
        rd_pend_q <= stream_go || (rd_pend_q && !out_free);
        if (stream_go) rd_cnt_q <= rd_cnt_q + (BeatW+1)'(1);
        if (stream_load) out_v_q <= 1'b1;
        if (stream_load && rd_cnt_q == (BeatW+1)'(BlockWords))
          state_q <= S_FIRST;
      end
    end
  end

  // Capture first word and build results.
  always_ff @(posedge clk_i) begin
    if (state_q == S_FIRST && acc) first_q <= req.data;
    if (state_q == S_WAIT) begin
      out_q.status      <= (first_q.opcode == OP_INVALID) ? ST_REJECT : dec_st;
      out_q.read_word   <= '0;
      out_q.last_of_run <= 1'b1;
      out_q.queries_seen <= (first_q.opcode == OP_LOOKUP && enable_q) ?
                            sat_inc(queries_q) : queries_q;
      out_q.hits_seen   <= (first_q.opcode == OP_LOOKUP && enable_q && dec_st == ST_OK) ?
                           sat_inc(hits_q) : hits_q;
    end
    if (state_q == S_BEATS && acc && last_beat) begin
      out_q.status       <= pend_st_q;
      out_q.read_word    <= '0;
      out_q.last_of_run  <= 1'b1;
      out_q.queries_seen <= queries_q;
      out_q.hits_seen    <= hits_q;
    end
    if (stream_load) begin
      out_q.status       <= ST_OK;
      out_q.read_word    <= rd_data;
      out_q.last_of_run  <= (rd_cnt_q == (BeatW+1)'(BlockWords)) && !stream_go;
      out_q.queries_seen <= queries_q;
      out_q.hits_seen    <= hits_q;
    end
  end

endmodule

`default_nettype wire

// File: hdl/lbc_checker.sv
// ============================================================================
// lbc_checker: port-level checks of the LRU block cache.
// Watches the top-level channels over time; bound to the top level.
// ============================================================================
`default_nettype none

module lbc_checker (
  input wire logic          clk_i,
  input wire logic          rst_ni,
  input wire logic          rsp_valid,
  input wire logic          rsp_ready,
  input wire lbc_pkg::rsp_t rsp_data,
  input wire logic          req_valid,
  input wire logic          req_ready
);
  import lbc_pkg::*;

  // A stalled result word holds.
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
    else $error("result changed while stalled");

  // The query count never decreases across back-to-back result words.
  a_mono: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid && rsp_ready ##1 rsp_valid |->
      rsp_data.queries_seen >= $past(rsp_data.queries_seen))
    else $error("query count went down");

  // Hits never exceed queries.
  a_hits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid |-> rsp_data.hits_seen <= rsp_data.queries_seen)
    else $error("more hits than queries");

  // Results with a status other than OK carry a zero word and last_of_run.
  a_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid && rsp_data.status != ST_OK |-> rsp_data.read_word == '0 &&
      rsp_data.last_of_run)
    else $error("non-hit result malformed");

  // No request word is taken while a result word is stalled.
  a_take: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_valid && req_ready |-> !rsp_valid || rsp_ready)
    else $error("request taken over a stalled result");

endmodule

bind lru_block_cache_unit lbc_checker u_lbc_checker (
  .clk_i     (clk_i),
  .rst_ni    (rst_ni),
  .rsp_valid (rsp.valid),
  .rsp_ready (rsp.ready),
  .rsp_data  (rsp.data),
  .req_valid (req.valid),
  .req_ready (req.ready)
);

`default_nettype wire
